[rtl/core/vdt_pkg.sv]
// ----------------------------------------------------------------------------
// vdt_pkg
// Shared types, sizes and codes for the vertex dedup table.
// ----------------------------------------------------------------------------
package vdt_pkg;

  // Table geometry
  localparam int MAX_VERTS = 1024;
  localparam int IDX_W     = $clog2(MAX_VERTS);
  localparam int CNT_W     = $clog2(MAX_VERTS) + 1;

  // Field widths
  localparam int COORD_W   = 32;
  localparam int TOL_W     = 20;
  localparam int OUT_IDX_W = 10;
  localparam int OP_W      = 2;
  localparam int ST_W      = 2;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(10);

  // Operation codes; the unnamed fourth code behaves as clear
  typedef enum logic [OP_W-1:0] {
    OP_UNIQUE = 2'd0,
    OP_ALWAYS = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_ADDED   = 2'd0,
    ST_MATCH   = 2'd1,
    ST_FULL    = 2'd2,
    ST_CLEARED = 2'd3
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_APPEND,
    S_EMIT
  } state_e;

  // One stored vertex
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vert_t;

  // Request from the controller to the vertex memory
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    vert_t            wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

[rtl/core/vdt_if.sv]
// ----------------------------------------------------------------------------
// vdt_if
// Valid/ready channels of the vertex dedup table: input items, results and
// tolerance register writes.
// ----------------------------------------------------------------------------

// Input item channel
interface vdt_in_if;
  logic                               valid;
  logic                               ready;
  logic [vdt_pkg::OP_W-1:0]           opcode;
  logic signed [vdt_pkg::COORD_W-1:0] pos_x;
  logic signed [vdt_pkg::COORD_W-1:0] pos_y;
  logic signed [vdt_pkg::COORD_W-1:0] pos_z;

  modport source (output valid, opcode, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, opcode, pos_x, pos_y, pos_z, output ready);
endinterface

// Result channel
interface vdt_out_if;
  logic                          valid;
  logic                          ready;
  logic [vdt_pkg::OUT_IDX_W-1:0] vertex_index;
  logic [vdt_pkg::ST_W-1:0]      status;

  modport source (output valid, vertex_index, status, input ready);
  modport sink   (input valid, vertex_index, status, output ready);
endinterface

// Tolerance register write channel
interface vdt_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [vdt_pkg::TOL_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[rtl/core/vertex_dedup_table_core.sv]
// ----------------------------------------------------------------------------
// vertex_dedup_table_core
// Vertex welding table with a per-axis tolerance.
//
// Channels: in_i carries one operation per beat (insert unique, insert
// always, clear) with a signed Q12.20 position; out_o returns one result
// beat per item (vertex index and status); cfg_i writes the match
// tolerance and is always ready.
// Sequence: a clear goes from the accepting state straight to the emit
// state, which loads the result register; insert always passes through the
// append state first; insert unique first searches the table: the search
// reads the vertex memory one entry per cycle, newest first, through its
// single read port, and stops at the first match.
// Throughput: one item at a time; the next item is accepted in the cycle
// after the previous result is loaded into the output register.
// Reset: the table is empty and the tolerance is 10; no clearing pass.
// Stall: a result waits in the output register while the next item is
// searched; the sequencer holds a finished result until that register frees.
// ----------------------------------------------------------------------------
module vertex_dedup_table_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  vdt_in_if.sink     in_i,
  vdt_out_if.source  out_o,
  vdt_cfg_if.sink    cfg_i
);
  import vdt_pkg::*;

  mem_req_t         mem_req;
  vert_t            rdata;
  vert_t            key;
  logic [TOL_W-1:0] tol;
  logic             hit;

  // sequencer
  vdt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .cfg_i     (cfg_i),
    .mem_req_o (mem_req),
    .key_o     (key),
    .tol_o     (tol),
    .hit_i     (hit)
  );

  // vertex memory
  vdt_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // tolerance compare on the read data
  vdt_match u_match (
    .entry_i (rdata),
    .key_i   (key),
    .tol_i   (tol),
    .hit_o   (hit)
  );

endmodule

[rtl/core/vdt_store.sv]
// ----------------------------------------------------------------------------
// vdt_store
// Vertex memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vdt_store (
  input  logic              clk_i,
  input  vdt_pkg::mem_req_t req_i,
  output vdt_pkg::vert_t    rdata_o
);
  import vdt_pkg::*;

  vert_t mem [MAX_VERTS];
  vert_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/vdt_match.sv]
// ----------------------------------------------------------------------------
// vdt_match
// Three-axis tolerance compare of a stored vertex against the search key.
// ----------------------------------------------------------------------------
module vdt_match (
  input  vdt_pkg::vert_t             entry_i,
  input  vdt_pkg::vert_t             key_i,
  input  logic [vdt_pkg::TOL_W-1:0]  tol_i,
  output logic                       hit_o
);
  import vdt_pkg::*;

  // |a - b| < tol  <=>  (a - b) < tol and (b - a) < tol, in 33 bits
  function automatic logic axis_close(input logic signed [COORD_W-1:0] a,
                                      input logic signed [COORD_W-1:0] b,
                                      input logic [TOL_W-1:0] tol);
    logic signed [COORD_W:0] ax;
    logic signed [COORD_W:0] bx;
    logic signed [COORD_W:0] tx;
    logic signed [COORD_W:0] d_ab;
    logic signed [COORD_W:0] d_ba;
    ax   = {a[COORD_W-1], a};
    bx   = {b[COORD_W-1], b};
    tx   = $signed({{(COORD_W+1-TOL_W){1'b0}}, tol});
    d_ab = ax - bx;
    d_ba = bx - ax;
    return (d_ab < tx) && (d_ba < tx);
  endfunction

  assign hit_o = axis_close(entry_i.x, key_i.x, tol_i) &&
                 axis_close(entry_i.y, key_i.y, tol_i) &&
                 axis_close(entry_i.z, key_i.z, tol_i);

endmodule

[rtl/core/vdt_ctrl.sv]
// ----------------------------------------------------------------------------
// vdt_ctrl
// Sequencer: accepts items, walks the table newest to oldest, appends,
// clears, holds the tolerance register and the output register.
// ----------------------------------------------------------------------------
module vdt_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  vdt_in_if.sink                     in_i,
  vdt_out_if.source                  out_o,
  vdt_cfg_if.sink                    cfg_i,
  output vdt_pkg::mem_req_t          mem_req_o,
  output vdt_pkg::vert_t             key_o,
  output logic [vdt_pkg::TOL_W-1:0]  tol_o,
  input  logic                       hit_i
);
  import vdt_pkg::*;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [TOL_W-1:0]       tol_q, tol_d;
  vert_t                  item_q, item_d;
  logic [IDX_W-1:0]       rd_idx_q, rd_idx_d;
  logic                   rd_more_q, rd_more_d;
  logic                   p_vld_q, p_vld_d;
  logic                   p_last_q, p_last_d;
  logic [IDX_W-1:0]       p_idx_q, p_idx_d;
  logic [IDX_W-1:0]       res_idx_q, res_idx_d;
  status_e                res_st_q, res_st_d;
  logic                   out_vld_q, out_vld_d;
  logic [OUT_IDX_W-1:0]   out_idx_q, out_idx_d;
  status_e                out_st_q, out_st_d;
  logic                   in_rdy;
  logic                   in_fire;
  logic                   is_clear;
  mem_req_t               req;

  assign in_rdy   = (state_q == S_IDLE);
  assign in_fire  = in_i.valid && in_rdy;
  // the fourth opcode acts as clear
  assign is_clear = (in_i.opcode != OP_UNIQUE) && (in_i.opcode != OP_ALWAYS);

  // next state and datapath control
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    tol_d     = tol_q;
    item_d    = item_q;
    rd_idx_d  = rd_idx_q;
    rd_more_d = rd_more_q;
    p_vld_d   = 1'b0;
    p_last_d  = p_last_q;
    p_idx_d   = p_idx_q;
    res_idx_d = res_idx_q;
    res_st_d  = res_st_q;
    out_vld_d = out_vld_q;
    out_idx_d = out_idx_q;
    out_st_d  = out_st_q;
    req       = '0;

    // tolerance write
    if (cfg_i.valid) begin
      tol_d = cfg_i.data;
    end

    // output register drains
    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          item_d = '{x: in_i.pos_x, y: in_i.pos_y, z: in_i.pos_z};
          if (is_clear) begin
            cnt_d     = '0;
            res_idx_d = '0;
            res_st_d  = ST_CLEARED;
            state_d   = S_EMIT;
          end else if ((in_i.opcode == OP_ALWAYS) || (cnt_q == '0)) begin
            state_d = S_APPEND;
          end else begin
            rd_idx_d  = IDX_W'(cnt_q - CNT_W'(1));
            rd_more_d = 1'b1;
            state_d   = S_SEARCH;
          end
        end
      end

      S_SEARCH: begin
        // issue one read a cycle, newest first
        if (rd_more_q) begin
          req.re    = 1'b1;
          req.raddr = rd_idx_q;
          p_vld_d   = 1'b1;
          p_idx_d   = rd_idx_q;
          p_last_d  = (rd_idx_q == '0);
          rd_idx_d  = rd_idx_q - IDX_W'(1);
          rd_more_d = (rd_idx_q != '0);
        end
        // check the entry that came back
        if (p_vld_q && hit_i) begin
          res_idx_d = p_idx_q;
          res_st_d  = ST_MATCH;
          p_vld_d   = 1'b0;
          rd_more_d = 1'b0;
          state_d   = S_EMIT;
        end else if (p_vld_q && p_last_q) begin
          state_d = S_APPEND;
        end
      end

      S_APPEND: begin
        if (cnt_q == CNT_W'(MAX_VERTS)) begin
          res_idx_d = '0;
          res_st_d  = ST_FULL;
        end else begin
          req.we    = 1'b1;
          req.waddr = cnt_q[IDX_W-1:0];
          req.wdata = item_q;
          res_idx_d = cnt_q[IDX_W-1:0];
          res_st_d  = ST_ADDED;
          cnt_d     = cnt_q + CNT_W'(1);
        end
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d = 1'b1;
          out_idx_d = OUT_IDX_W'(res_idx_q);
          out_st_d  = res_st_q;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      tol_q     <= TOL_RESET;
      rd_more_q <= 1'b0;
      p_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      tol_q     <= tol_d;
      rd_more_q <= rd_more_d;
      p_vld_q   <= p_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    rd_idx_q  <= rd_idx_d;
    p_last_q  <= p_last_d;
    p_idx_q   <= p_idx_d;
    res_idx_q <= res_idx_d;
    res_st_q  <= res_st_d;
    out_idx_q <= out_idx_d;
    out_st_q  <= out_st_d;
  end

  assign in_i.ready         = in_rdy;
  assign cfg_i.ready        = 1'b1;
  assign out_o.valid        = out_vld_q;
  assign out_o.vertex_index = out_idx_q;
  assign out_o.status       = out_st_q;
  assign mem_req_o          = req;
  assign key_o              = item_q;
  assign tol_o              = tol_q;

  // a write never lands past the end of the table
  a_we_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.we |-> (cnt_q < CNT_W'(MAX_VERTS)))
    else $error("vdt_ctrl: write with table full");

  // every write grows the table by exactly one
  a_we_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.we |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("vdt_ctrl: entry count out of step with writes");

  // read data is only examined during a search
  a_pipe_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_vld_q |-> (state_q == S_SEARCH))
    else $error("vdt_ctrl: read in flight outside search");

  // a clear empties the table at once
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_clear) |=> (cnt_q == '0))
    else $error("vdt_ctrl: clear left entries");

  // count never exceeds capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_VERTS))
    else $error("vdt_ctrl: entry count above capacity");

endmodule

[tb/sv/weld_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weld_checker
// Watches the item, result and tolerance channels of the vertex dedup table.
// Keeps its own copy of the vertex table, works out the result of every
// accepted item and compares each result beat with the oldest expectation.
// ----------------------------------------------------------------------------
module weld_checker import vdt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  vdt_in_if    in_mon,
  vdt_out_if   res_mon,
  vdt_cfg_if   cfg_mon,
  output int   fail_count_o,
  output int   pending_o
);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] idx;
    status_e              status;
  } weld_result_t;

  // Shadow table and tolerance
  coord_t             table_x [MAX_VERTS];
  coord_t             table_y [MAX_VERTS];
  coord_t             table_z [MAX_VERTS];
  logic [CNT_W-1:0]   entry_count;
  logic [TOL_W-1:0]   tolerance;
  weld_result_t       weld_q[$];
  int                 mismatches = 0;

  // Per-axis test on exact 33-bit differences
  function automatic bit axis_near(coord_t a, coord_t b);
    logic signed [COORD_W:0] diff;
    logic [COORD_W:0]        mag;
    diff = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    mag  = (diff < 0) ? -diff : diff;
    return mag < {{(COORD_W+1-TOL_W){1'b0}}, tolerance};
  endfunction

  // Applies one operation to the shadow table and returns its result
  function automatic weld_result_t weld_vertex(logic [OP_W-1:0] op, coord_t x, coord_t y,
                                               coord_t z);
    weld_result_t r;
    int unsigned  i;
    bit           hit;
    r.idx = '0;
    hit   = 1'b0;
    // upper opcode bit decodes as clear
    if (op[1]) begin
      entry_count = '0;
      r.status    = ST_CLEARED;
      return r;
    end
    // newest to oldest, first match wins
    if (op == OP_UNIQUE) begin
      i = entry_count;
      while (i > 0 && !hit) begin
        i--;
        if (axis_near(table_x[i], x) && axis_near(table_y[i], y) &&
            axis_near(table_z[i], z)) begin
          hit      = 1'b1;
          r.idx    = OUT_IDX_W'(i);
          r.status = ST_MATCH;
        end
      end
    end
    if (!hit) begin
      if (entry_count >= MAX_VERTS) begin
        r.status = ST_FULL;
      end else begin
        table_x[entry_count] = x;
        table_y[entry_count] = y;
        table_z[entry_count] = z;
        r.idx       = OUT_IDX_W'(entry_count);
        r.status    = ST_ADDED;
        entry_count = entry_count + 1'b1;
      end
    end
    return r;
  endfunction

  // Beat monitor: results are retired before the new item is queued
  always @(posedge clk_i or negedge rst_ni) begin
    weld_result_t want;
    if (!rst_ni) begin
      entry_count = '0;
      tolerance   = TOL_RESET;
      weld_q.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) tolerance = cfg_mon.data;

      if (res_mon.valid && res_mon.ready) begin
        if (weld_q.size() == 0) begin
          mismatches++;
          $error("result beat with nothing pending: vertex_index %0d status %0d",
                 res_mon.vertex_index, res_mon.status);
        end else begin
          want = weld_q.pop_front();
          if (res_mon.vertex_index !== want.idx) begin
            mismatches++;
            $error("vertex_index: expected %0d, got %0d", want.idx, res_mon.vertex_index);
          end
          if (res_mon.status !== want.status) begin
            mismatches++;
            $error("status: expected %0d, got %0d", want.status, res_mon.status);
          end
        end
      end

      if (in_mon.valid && in_mon.ready)
        weld_q.push_back(weld_vertex(in_mon.opcode, in_mon.pos_x, in_mon.pos_y,
                                     in_mon.pos_z));

      pending_o    <= weld_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the vertex dedup table. A directed run covers
// coordinate extremes, every opcode and tolerance edges; random segments
// under several tolerances and idling mixes follow. Checking is done by
// weld_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import vdt_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam int              LIMIT_CYCLES = 1000000;
  localparam int              HOLD_CYCLES  = 1500;
  localparam int              SEG_ITEMS    = 70;
  localparam int              SEG_COUNT    = 8;
  localparam int              CLEAR_EVERY  = 60;
  // unnamed fourth opcode, decodes as clear
  localparam logic [OP_W-1:0] OP_CLEAR_ALT = 2'b11;

  logic clk;
  logic rst_n;
  int   cycles;
  int   fail_count;
  int   pending;

  // Idling controls and long receiver hold-off
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_req;
  int   hold_ack;
  int   hold_left;

  // Recently sent positions, used to aim at stored vertices
  coord_t      sent_x[$];
  coord_t      sent_y[$];
  coord_t      sent_z[$];
  int unsigned since_clear;
  int unsigned tol_now;

  vdt_in_if  in_bus ();
  vdt_out_if res_bus ();
  vdt_cfg_if cfg_bus ();

  vertex_dedup_table_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  weld_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon       (in_bus),
    .res_mon      (res_bus),
    .cfg_mon      (cfg_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock and known input levels from time zero
  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    cycles         = 0;
    in_bus.valid   = 1'b0;
    in_bus.opcode  = '0;
    in_bus.pos_x   = '0;
    in_bus.pos_y   = '0;
    in_bus.pos_z   = '0;
    res_bus.ready  = 1'b0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.data   = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 0;
    hold_ack       = 0;
    hold_left      = 0;
    since_clear    = 0;
    tol_now        = TOL_RESET;
  end

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Result receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack      <= hold_req;
      hold_left     <= HOLD_CYCLES;
      res_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(3))
      0:       return coord_t'($urandom);
      1:       return coord_t'($urandom_range(8191)) - 4096;
      2:       return coord_t'(32'h7FFF_FFFF) - coord_t'($urandom_range(15));
      default: return coord_t'(32'h8000_0000) + coord_t'($urandom_range(15));
    endcase
  endfunction

  // Offset a coordinate to land on it, just inside the tolerance, or on the tolerance
  function automatic coord_t nudge(coord_t c, int unsigned tol);
    int unsigned spread;
    int unsigned mag;
    spread = (tol == 0) ? 1 : tol;
    case ($urandom_range(3))
      0:       mag = 0;
      1:       mag = spread - 1;
      2:       mag = spread;
      default: mag = $urandom_range(spread);
    endcase
    return $urandom_range(1) ? c + coord_t'(mag) : c - coord_t'(mag);
  endfunction

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct   = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // Offer one item and wait for its beat
  task automatic send_item(logic [OP_W-1:0] op, coord_t x, coord_t y, coord_t z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.opcode <= op;
    in_bus.pos_x  <= x;
    in_bus.pos_y  <= y;
    in_bus.pos_z  <= z;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (op[1]) begin
      sent_x.delete();
      sent_y.delete();
      sent_z.delete();
      since_clear = 0;
    end else begin
      sent_x.push_back(x);
      sent_y.push_back(y);
      sent_z.push_back(z);
      since_clear++;
    end
  endtask

  // Wait until every expected result has come back, then a short tail
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] tol);
    wait_drained();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= tol;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    tol_now = tol;
  endtask

  // Mostly hits on stored vertices, some misses, appends and clears
  task automatic random_item();
    int unsigned     pick;
    int unsigned     k;
    coord_t          x;
    coord_t          y;
    coord_t          z;
    logic [OP_W-1:0] op;
    pick = $urandom_range(99);
    x    = rand_coord();
    y    = rand_coord();
    z    = rand_coord();
    op   = OP_UNIQUE;
    if (since_clear >= CLEAR_EVERY || pick < 5) begin
      op = $urandom_range(1) ? OP_CLEAR : OP_CLEAR_ALT;
    end else if (sent_x.size() > 0 && pick < 65) begin
      k = $urandom_range(sent_x.size() - 1);
      if (pick < 18) begin
        x = sent_x[k];
        y = sent_y[k];
        z = sent_z[k];
      end else begin
        x = nudge(sent_x[k], tol_now);
        y = nudge(sent_y[k], tol_now);
        z = nudge(sent_z[k], tol_now);
      end
      if (pick >= 55) op = OP_ALWAYS;
    end else if (pick >= 85) begin
      op = OP_ALWAYS;
    end
    send_item(op, x, y, z);
  endtask

  initial begin
    int unsigned seg;
    int unsigned n;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: tolerance at its reset value of 10
    send_item(OP_UNIQUE, 0, 0, 0);
    send_item(OP_UNIQUE, 9, -9, 9);
    send_item(OP_UNIQUE, 10, 0, 0);
    send_item(OP_UNIQUE, 0, -10, 0);
    send_item(OP_ALWAYS, 0, 0, 0);
    send_item(OP_UNIQUE, 1, 1, 1);
    send_item(OP_UNIQUE, 0, 0, 10);
    // opposite ends of the range must not wrap into a match
    send_item(OP_UNIQUE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(OP_UNIQUE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(OP_UNIQUE, 32'h7FFF_FFF7, 32'h7FFF_FFF7, 32'h7FFF_FFF7);
    send_item(OP_UNIQUE, 32'h8000_0009, 32'h8000_0009, 32'h8000_0009);
    send_item(OP_ALWAYS, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_item(OP_UNIQUE, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_item(OP_UNIQUE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_555E);
    send_item(OP_CLEAR_ALT, -1, -1, -1);
    send_item(OP_UNIQUE, 0, 0, 0);
    send_item(OP_CLEAR, 32'h7FFF_FFFF, 0, 32'h8000_0000);
    send_item(OP_ALWAYS, -1, -1, -1);
    send_item(OP_UNIQUE, -1, -1, -1);

    // Random segments: tolerance and idling mix change between them
    for (seg = 0; seg < SEG_COUNT; seg++) begin
      case (seg)
        0:       ;
        1:       write_tolerance(1);
        2:       write_tolerance(20'hF_FFFF);
        3:       write_tolerance(0);
        default: write_tolerance((seg % 2 == 0) ? TOL_W'($urandom_range(2, 64))
                                                : TOL_W'($urandom_range(1, 20'hF_FFFF)));
      endcase
      case (seg % 4)
        0:       set_idling(0, 0);
        1:       set_idling(76, 0);
        2:       set_idling(0, 76);
        default: set_idling(6, 6);
      endcase
      for (n = 0; n < SEG_ITEMS; n++) begin
        // receiver holds off while items keep coming
        if (seg == 0 && n == 20) hold_req <= hold_req + 1;
        random_item();
      end
    end

    wait_drained();
    if (fail_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
